@@ rtl/core/rmfb_pkg.sv @@
// Shared constants and types for the rotated monochrome framebuffer.
`timescale 1ns / 1ps

package rmfb_pkg;

    // Screen geometry
    localparam int SCREEN_WIDTH  = 128;
    localparam int SCREEN_HEIGHT = 32;
    localparam int PAGE_BYTES    = (SCREEN_HEIGHT + 7) / 8;
    localparam int STORE_BYTES   = PAGE_BYTES * SCREEN_WIDTH;

    // Derived widths
    localparam int ADDR_W = $clog2(STORE_BYTES);
    localparam int XW     = $clog2(SCREEN_WIDTH);
    localparam int YW     = $clog2(SCREEN_HEIGHT);

    // Bit mask of the first pixel in a byte, MSB first
    localparam logic [7:0] PIXEL_MSB = 8'h80;

    // Request codes
    localparam logic [1:0] REQ_SET  = 2'd0;
    localparam logic [1:0] REQ_FILL = 2'd1;
    localparam logic [1:0] REQ_READ = 2'd2;
    localparam logic [1:0] REQ_NONE = 2'd3;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [7:0]         rect_width;
        logic [7:0]         rect_height;
        logic               paint_white;
        logic [1:0]         page_index;
        logic [6:0]         column_index;
    } req_t;

    typedef struct packed {
        logic       status;
        logic [7:0] read_byte;
    } rsp_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic clear_wr;
        logic pix_rd;
        logic pix_wr;
        logic step;
        logic byte_rd;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [1:0] kind;
        logic       pix_on;
        logic       rect_reject;
        logic       rect_empty;
        logic       pix_last;
        logic       clear_last;
    } stat_t;

endpackage

@@ rtl/core/rotated_mono_framebuffer.sv @@
// Top level of the rotated monochrome framebuffer.
`timescale 1ns / 1ps
// A read passes through decode, a registered byte read and the result strobe; an on-screen set-pixel
// does one pixel read-modify-write; an off-screen pixel, a rejected or empty fill or an unused request
// code goes from decode straight to the result strobe; an accepted fill repeats it for each pixel.
// Each pixel read-modify-write on the memory is a registered read, then a write.
// A new request is taken in the cycle its predecessor's result is strobed.
// After reset the memory is cleared to zero with busy high.

module rotated_mono_framebuffer
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  rmfb_pkg::req_t req,
    output logic           done,
    output rmfb_pkg::rsp_t rsp
);

    rmfb_pkg::cmd_t  cmd;
    rmfb_pkg::stat_t stat;

    // Sequencer
    rmfb_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // Memory and address datapath
    rmfb_datapath u_datapath
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .stat  (stat),
        .rsp   (rsp)
    );

endmodule

@@ rtl/core/rmfb_datapath.sv @@
// Datapath: request register, pixel cursor, clear counter and pixel memory.
`timescale 1ns / 1ps

module rmfb_datapath
(
    input  logic           clk,
    input  logic           rst_n,
    input  rmfb_pkg::req_t req,
    input  rmfb_pkg::cmd_t cmd,
    output rmfb_pkg::stat_t stat,
    output rmfb_pkg::rsp_t rsp
);

    localparam logic signed [17:0] WIDTH_S  = 18'(rmfb_pkg::SCREEN_WIDTH);
    localparam logic signed [17:0] HEIGHT_S = 18'(rmfb_pkg::SCREEN_HEIGHT);

    rmfb_pkg::req_t                 req_reg;
    logic [rmfb_pkg::XW-1:0]        cur_x_reg;
    logic [rmfb_pkg::YW-1:0]        cur_y_reg;
    logic [rmfb_pkg::ADDR_W-1:0]    clr_cnt_reg;
    logic [7:0]                     rdata_reg;
    logic [7:0]                     pixel_store_reg [rmfb_pkg::STORE_BYTES];

    logic signed [17:0]             x_ext;
    logic signed [17:0]             y_ext;
    logic signed [17:0]             x_end;
    logic signed [17:0]             y_end;
    logic [rmfb_pkg::XW-1:0]        x_last;
    logic [rmfb_pkg::YW-1:0]        y_last;
    logic [rmfb_pkg::YW-1:0]        col;
    logic [7:0]                     mask;
    logic [7:0]                     pix_wdata;
    logic [rmfb_pkg::ADDR_W-1:0]    pix_addr;
    logic [rmfb_pkg::ADDR_W-1:0]    byte_addr;
    logic                           read_ok;
    logic                           mem_we;
    logic [rmfb_pkg::ADDR_W-1:0]    mem_waddr;
    logic [7:0]                     mem_wdata;
    logic [rmfb_pkg::ADDR_W-1:0]    mem_raddr;

    // Bounds of the latched request
    always_comb
    begin
        x_ext = {{2{req_reg.pos_x[15]}}, req_reg.pos_x};
        y_ext = {{2{req_reg.pos_y[15]}}, req_reg.pos_y};
        x_end = x_ext + $signed({10'd0, req_reg.rect_width});
        y_end = y_ext + $signed({10'd0, req_reg.rect_height});
        x_last = req_reg.pos_x[rmfb_pkg::XW-1:0]
               + rmfb_pkg::XW'(req_reg.rect_width) - rmfb_pkg::XW'(1);
        y_last = req_reg.pos_y[rmfb_pkg::YW-1:0]
               + rmfb_pkg::YW'(req_reg.rect_height) - rmfb_pkg::YW'(1);
    end

    // Map the cursor pixel to its byte and bit
    always_comb
    begin
        col = rmfb_pkg::YW'(rmfb_pkg::SCREEN_HEIGHT - 1) - cur_y_reg;
        mask = rmfb_pkg::PIXEL_MSB >> col[2:0];
        pix_addr = rmfb_pkg::ADDR_W'(col >> 3)
                 + rmfb_pkg::ADDR_W'(cur_x_reg) * rmfb_pkg::ADDR_W'(rmfb_pkg::PAGE_BYTES);
        pix_wdata = req_reg.paint_white ? (rdata_reg | mask) : (rdata_reg & ~mask);
    end

    // Scan-out address of a display byte
    always_comb
    begin
        read_ok = (32'(req_reg.page_index) < rmfb_pkg::PAGE_BYTES) &&
                  (32'(req_reg.column_index) < rmfb_pkg::SCREEN_WIDTH);
        byte_addr = rmfb_pkg::ADDR_W'(rmfb_pkg::PAGE_BYTES - 1)
                  - rmfb_pkg::ADDR_W'(req_reg.page_index)
                  + rmfb_pkg::ADDR_W'(req_reg.column_index)
                  * rmfb_pkg::ADDR_W'(rmfb_pkg::PAGE_BYTES);
    end

    // Status to the controller
    always_comb
    begin
        stat.kind        = req_reg.req_type;
        stat.pix_on      = !x_ext[17] && !y_ext[17] && (x_ext < WIDTH_S) && (y_ext < HEIGHT_S);
        stat.rect_reject = x_ext[17] || y_ext[17] || (x_end > WIDTH_S) || (y_end > HEIGHT_S);
        stat.rect_empty  = (req_reg.rect_width == 8'd0) || (req_reg.rect_height == 8'd0);
        stat.pix_last    = (cur_x_reg == x_last) && (cur_y_reg == y_last);
        stat.clear_last  = clr_cnt_reg == rmfb_pkg::ADDR_W'(rmfb_pkg::STORE_BYTES - 1);
    end

    // Result fields
    always_comb
    begin
        rsp.status    = (req_reg.req_type == rmfb_pkg::REQ_FILL) && stat.rect_reject;
        rsp.read_byte = ((req_reg.req_type == rmfb_pkg::REQ_READ) && read_ok) ? rdata_reg : 8'd0;
    end

    // Hold the request and walk the cursor over the rectangle
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg   <= req;
            cur_x_reg <= req.pos_x[rmfb_pkg::XW-1:0];
            cur_y_reg <= req.pos_y[rmfb_pkg::YW-1:0];
        end
        else if (cmd.step)
        begin
            if (cur_y_reg == y_last)
            begin
                cur_y_reg <= req_reg.pos_y[rmfb_pkg::YW-1:0];
                cur_x_reg <= cur_x_reg + rmfb_pkg::XW'(1);
            end
            else
            begin
                cur_y_reg <= cur_y_reg + rmfb_pkg::YW'(1);
            end
        end
    end

    // Advance the clear counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear_wr)
        begin
            clr_cnt_reg <= clr_cnt_reg + rmfb_pkg::ADDR_W'(1);
        end
    end

    // Memory port selection
    always_comb
    begin
        mem_we    = cmd.clear_wr || cmd.pix_wr;
        mem_waddr = cmd.clear_wr ? clr_cnt_reg : pix_addr;
        mem_wdata = cmd.clear_wr ? 8'd0 : pix_wdata;
        mem_raddr = cmd.byte_rd ? byte_addr : pix_addr;
    end

    // Pixel memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            pixel_store_reg[mem_waddr] <= mem_wdata;
        end
        if (cmd.pix_rd || cmd.byte_rd)
        begin
            rdata_reg <= pixel_store_reg[mem_raddr];
        end
    end

    a_no_wr_during_rd: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && (cmd.pix_rd || cmd.byte_rd)))
        else $error("memory written and read in one cycle");

    a_clear_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_wr |-> !cmd.load && !cmd.pix_wr)
        else $error("clear write overlaps request work");

    a_step_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> req_reg.req_type == rmfb_pkg::REQ_FILL && !stat.pix_last)
        else $error("cursor stepped outside a fill");

endmodule

@@ rtl/core/rmfb_ctrl.sv @@
// Controller: sequences clearing, pixel read-modify-write and byte reads.
`timescale 1ns / 1ps

module rmfb_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  rmfb_pkg::stat_t stat,
    output rmfb_pkg::cmd_t  cmd,
    output logic            busy,
    output logic            done
);

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_DECODE = 7'b0000100,
        S_PIX_RD = 7'b0001000,
        S_PIX_WR = 7'b0010000,
        S_READ   = 7'b0100000,
        S_DONE   = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign busy   = !((state_reg == S_IDLE) || (state_reg == S_DONE));
    assign done   = state_reg == S_DONE;
    assign accept = start && !busy;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        cmd.load = accept;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (stat.kind)
                    rmfb_pkg::REQ_SET:
                        state_next = stat.pix_on ? S_PIX_RD : S_DONE;
                    rmfb_pkg::REQ_FILL:
                        state_next = (stat.rect_reject || stat.rect_empty) ? S_DONE : S_PIX_RD;
                    rmfb_pkg::REQ_READ:
                        state_next = S_READ;
                    default:
                        state_next = S_DONE;
                endcase
            end
            S_PIX_RD:
            begin
                cmd.pix_rd = 1'b1;
                state_next = S_PIX_WR;
            end
            S_PIX_WR:
            begin
                cmd.pix_wr = 1'b1;
                if ((stat.kind == rmfb_pkg::REQ_SET) || stat.pix_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.step = 1'b1;
                    state_next = S_PIX_RD;
                end
            end
            S_READ:
            begin
                cmd.byte_rd = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = accept ? S_DECODE : S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held longer than one cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("not busy after a transfer");

    a_write_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pix_wr |-> $past(cmd.pix_rd))
        else $error("pixel write without a preceding read");

endmodule
